@@ rtl/core/orb_pkg.sv @@
// Shared types, sizes and helpers for the overwriting ring buffer.
// No dependencies; orb_queue, orb_front, orb_back and the top level import this package.
package orb_pkg;

   localparam int CAPACITY    = 32;
   localparam int SAMPLE_BITS = 64;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Fixed port widths
   localparam int ACTION_W = 2;
   localparam int DATA_W   = 64;
   localparam int REQ_W    = 7;
   localparam int FILL_W   = 7;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH  = 2'd0,
      ACT_POP   = 2'd1,
      ACT_PEEK  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   // One unit of work for the back end: n words from addr, or a single
   // status word when n is zero.
   typedef struct packed {
      logic [IDX_W-1:0]  addr;
      logic [CNT_W-1:0]  n;
      logic [FILL_W-1:0] fill;
      logic              full;
      logic              ovw;
   } job_type;

   // Fold a sum below twice the capacity back into the index range.
   function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W:0] v);
      logic [IDX_W:0] r;
      r = (v >= (IDX_W+1)'(CAPACITY)) ? v - (IDX_W+1)'(CAPACITY) : v;
      return r[IDX_W-1:0];
   endfunction

endpackage

@@ rtl/core/orb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module orb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/orb_queue.sv @@
// Short job queue between the front and back ends.
// Depends on orb_pkg (job_type, QUEUE_DEPTH).
module orb_queue
   import orb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/core/orb_front.sv @@
// Front end: takes commands, keeps the ring pointers and fill count,
// writes pushed samples and hands jobs to the queue. Depends on orb_pkg.
module orb_front
   import orb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [DATA_W-1:0]      req_sample,
   input  logic [REQ_W-1:0]       req_request_count,
   input  logic                   q_full,
   output logic                   q_push,
   output job_type                q_job,
   input  logic                   read_done,
   output logic                   ram_wr_en,
   output logic [IDX_W-1:0]       ram_wr_addr,
   output logic [SAMPLE_BITS-1:0] ram_wr_data
);

   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             accept;
   logic             is_full;
   logic [CNT_W-1:0] take;
   action_type       act;

   assign act     = action_type'(req_action);
   assign busy    = q_full || rd_pend_ff;
   assign accept  = start && !busy;
   assign is_full = (cnt_ff == CNT_W'(CAPACITY));

   // saturate the request to what is stored
   assign take = (req_request_count < FILL_W'(cnt_ff)) ?
                 CNT_W'(req_request_count) : cnt_ff;

   assign ram_wr_en   = accept && (act == ACT_PUSH);
   assign ram_wr_addr = wr_idx_ff;
   assign ram_wr_data = req_sample[SAMPLE_BITS-1:0];
   assign q_push      = accept;

   always_comb begin
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      cnt_in     = cnt_ff;
      rd_pend_in = rd_pend_ff && !read_done;
      q_job.addr = rd_idx_ff;
      q_job.n    = '0;
      q_job.ovw  = 1'b0;
      if (accept) begin
         unique case (act)
            ACT_PUSH: begin
               wr_idx_in = wrap_idx({1'b0, wr_idx_ff} + (IDX_W+1)'(1));
               if (is_full) begin
                  rd_idx_in = wrap_idx({1'b0, rd_idx_ff} + (IDX_W+1)'(1));
                  q_job.ovw = 1'b1;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
            ACT_POP: begin
               q_job.n   = take;
               q_job.addr = rd_idx_ff;
               rd_idx_in = wrap_idx({1'b0, rd_idx_ff} + (IDX_W+1)'(take));
               cnt_in    = cnt_ff - take;
               rd_pend_in = (take != '0);
            end
            ACT_PEEK: begin
               q_job.n    = take;
               q_job.addr = wrap_idx({1'b0, wr_idx_ff} + (IDX_W+1)'(CAPACITY)
                                     - (IDX_W+1)'(take));
               rd_pend_in = (take != '0);
            end
            ACT_CLEAR: begin
               wr_idx_in = '0;
               rd_idx_in = '0;
               cnt_in    = '0;
            end
            default: ;
         endcase
      end
      q_job.fill = FILL_W'(cnt_in);
      q_job.full = (cnt_in == CNT_W'(CAPACITY));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff  <= '0;
         rd_idx_ff  <= '0;
         cnt_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         wr_idx_ff  <= wr_idx_in;
         rd_idx_ff  <= rd_idx_in;
         cnt_ff     <= cnt_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

endmodule

@@ rtl/core/orb_back.sv @@
// Back end: pulls jobs from the queue, reads the sample RAM one word a
// cycle and drives the result ports. Depends on orb_pkg.
module orb_back
   import orb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  job_type                q_head,
   output logic                   q_pop,
   output logic                   read_done,
   output logic                   ram_rd_en,
   output logic [IDX_W-1:0]       ram_rd_addr,
   input  logic [SAMPLE_BITS-1:0] ram_rd_data,
   output logic                   rsp_strobe,
   output logic [DATA_W-1:0]      rsp_sample_out,
   output logic                   rsp_sample_valid,
   output logic                   rsp_last,
   output logic [FILL_W-1:0]      rsp_fill_level,
   output logic                   rsp_full_res,
   output logic                   rsp_overwrote
);

   // current job
   logic              act_ff, act_in;
   logic              vld_ff, vld_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              full_ff, full_in;
   logic              ovw_ff, ovw_in;
   // word stage, lines up with the RAM read data
   logic              stb_ff;
   logic              wvld_ff;
   logic              wlast_ff;
   logic [FILL_W-1:0] wfill_ff;
   logic              wfull_ff;
   logic              wovw_ff;
   logic              beat_last;
   logic              load;

   assign beat_last = (left_ff == CNT_W'(1));
   assign load      = !act_ff || beat_last;
   assign q_pop     = load && !q_empty;
   assign read_done = act_ff && vld_ff && beat_last;
   assign ram_rd_en = act_ff && vld_ff;
   assign ram_rd_addr = addr_ff;

   always_comb begin
      act_in  = act_ff;
      vld_in  = vld_ff;
      addr_in = addr_ff;
      left_in = left_ff;
      fill_in = fill_ff;
      full_in = full_ff;
      ovw_in  = ovw_ff;
      if (load) begin
         act_in  = !q_empty;
         vld_in  = (q_head.n != '0);
         addr_in = q_head.addr;
         left_in = (q_head.n != '0) ? q_head.n : CNT_W'(1);
         fill_in = q_head.fill;
         full_in = q_head.full;
         ovw_in  = q_head.ovw;
      end else begin
         // advance through the run
         addr_in = wrap_idx({1'b0, addr_ff} + (IDX_W+1)'(1));
         left_in = left_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         stb_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
         stb_ff <= act_ff;
      end
   end

   always_ff @(posedge clock) begin
      vld_ff   <= vld_in;
      addr_ff  <= addr_in;
      left_ff  <= left_in;
      fill_ff  <= fill_in;
      full_ff  <= full_in;
      ovw_ff   <= ovw_in;
      wvld_ff  <= vld_ff;
      wlast_ff <= beat_last;
      wfill_ff <= fill_ff;
      wfull_ff <= full_ff;
      wovw_ff  <= ovw_ff;
   end

   assign rsp_strobe       = stb_ff;
   assign rsp_sample_out   = wvld_ff ? DATA_W'(ram_rd_data) : '0;
   assign rsp_sample_valid = wvld_ff;
   assign rsp_last         = wlast_ff;
   assign rsp_fill_level   = wfill_ff;
   assign rsp_full_res     = wfull_ff;
   assign rsp_overwrote    = wovw_ff;

endmodule

@@ rtl/core/overwriting_ring_buffer.sv @@
// Top level of the overwriting sample ring buffer.
// Depends on orb_pkg, orb_ram, orb_queue, orb_front and orb_back.
//
// A command is taken on a clock edge where start is high and busy is low.
// Push, clear and a pop or peek that has nothing to give each yield one
// result word, and while busy is low such commands can be issued every
// cycle: one per cycle sustained. A pop or peek returning n samples yields
// n words on consecutive cycles; busy stays high until the last of its RAM
// reads has been issued, and only then is the next command taken. The wait
// comes from the single read port of the sample RAM, one word per cycle.
// A job passes the queue slot and the back end's job registers before the
// RAM read. Result words are never held back: rsp_strobe marks each word
// for exactly one cycle and the receiver must take it.
module overwriting_ring_buffer
   import orb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [DATA_W-1:0]   req_sample,
   input  logic [REQ_W-1:0]    req_request_count,
   output logic                rsp_strobe,
   output logic [DATA_W-1:0]   rsp_sample_out,
   output logic                rsp_sample_valid,
   output logic                rsp_last,
   output logic [FILL_W-1:0]   rsp_fill_level,
   output logic                rsp_full_res,
   output logic                rsp_overwrote
);

   job_type                q_in_job;
   job_type                q_head;
   logic                   q_push, q_pop, q_empty, q_full;
   logic                   read_done;
   logic                   ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]       ram_wr_addr, ram_rd_addr;
   logic [SAMPLE_BITS-1:0] ram_wr_data, ram_rd_data;

   // Front: classify the command, update pointers, write pushed samples.
   orb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_sample        (req_sample),
      .req_request_count (req_request_count),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_job             (q_in_job),
      .read_done         (read_done),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data)
   );

   // Hold pending jobs so single-word commands stream without waiting.
   orb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_in_job),
      .pop      (q_pop),
      .head_job (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Sample storage: written by the front, read by the back.
   orb_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Back: walk each job one word per cycle and drive the result ports.
   orb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .read_done        (read_done),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_sample_valid (rsp_sample_valid),
      .rsp_last         (rsp_last),
      .rsp_fill_level   (rsp_fill_level),
      .rsp_full_res     (rsp_full_res),
      .rsp_overwrote    (rsp_overwrote)
   );

endmodule

@@ bench/orb_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the overwriting ring buffer: predicts every result word from
// the accepted commands and compares it with the word on the rsp_ ports.
// Depends on orb_pkg for sizes and the action codes.
module orb_checker
   import orb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [DATA_W-1:0]   req_sample,
   input  logic [REQ_W-1:0]    req_request_count,
   input  logic                rsp_strobe,
   input  logic [DATA_W-1:0]   rsp_sample_out,
   input  logic                rsp_sample_valid,
   input  logic                rsp_last,
   input  logic [FILL_W-1:0]   rsp_fill_level,
   input  logic                rsp_full_res,
   input  logic                rsp_overwrote,
   output int                  mismatch_count,
   output int                  words_owed
);

   localparam logic [DATA_W-1:0] KEEP_MASK = {DATA_W{1'b1}} >> (DATA_W - SAMPLE_BITS);

   typedef struct {
      logic [DATA_W-1:0] sample_out;
      logic              sample_valid;
      logic              last;
      logic [FILL_W-1:0] fill_level;
      logic              full_res;
      logic              overwrote;
   } rsp_word_type;

   rsp_word_type      owed_words[$];
   logic [DATA_W-1:0] ring[CAPACITY];
   int unsigned       wr_slot;
   int unsigned       rd_slot;
   int unsigned       level;

   initial begin
      mismatch_count = 0;
      words_owed     = 0;
      wr_slot        = 0;
      rd_slot        = 0;
      level          = 0;
   end

   // Build one result word; fill and full always reflect the state after the command.
   function automatic rsp_word_type make_word(logic [DATA_W-1:0] smp, logic valid,
                                              logic fin, logic ovw);
      rsp_word_type w;
      w.sample_out   = smp & KEEP_MASK;
      w.sample_valid = valid;
      w.last         = fin;
      w.fill_level   = FILL_W'(level);
      w.full_res     = (level == CAPACITY);
      w.overwrote    = ovw;
      return w;
   endfunction

   task automatic predict_words(input action_type act, input logic [DATA_W-1:0] smp,
                                input int unsigned want);
      int unsigned n;
      int unsigned first;
      logic        ovw;
      ovw = 1'b0;
      case (act)
         ACT_PUSH: begin
            if (level >= CAPACITY) begin
               rd_slot = (rd_slot + 1) % CAPACITY;
               ovw     = 1'b1;
            end else begin
               level++;
            end
            ring[wr_slot] = smp & KEEP_MASK;
            wr_slot       = (wr_slot + 1) % CAPACITY;
            owed_words.push_back(make_word('0, 1'b0, 1'b1, ovw));
         end
         ACT_CLEAR: begin
            wr_slot = 0;
            rd_slot = 0;
            level   = 0;
            owed_words.push_back(make_word('0, 1'b0, 1'b1, 1'b0));
         end
         default: begin
            n = (want < level) ? want : level;
            if (n == 0) begin
               owed_words.push_back(make_word('0, 1'b0, 1'b1, 1'b0));
            end else begin
               if (act == ACT_POP) begin
                  first   = rd_slot;
                  rd_slot = (rd_slot + n) % CAPACITY;
                  level   = level - n;
               end else begin
                  first = (wr_slot + CAPACITY - n) % CAPACITY;
               end
               for (int i = 0; i < n; i++)
                  owed_words.push_back(make_word(ring[(first + i) % CAPACITY], 1'b1,
                                                 (i + 1 == n), 1'b0));
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         owed_words.delete();
         wr_slot = 0;
         rd_slot = 0;
         level   = 0;
      end else begin
         if (rsp_strobe) begin
            if (owed_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected word sample=%h valid=%b last=%b fill=%0d",
                           $realtime, rsp_sample_out, rsp_sample_valid, rsp_last,
                           rsp_fill_level);
            end else begin
               exp_w = owed_words.pop_front();
               if (rsp_sample_out !== exp_w.sample_out ||
                   rsp_sample_valid !== exp_w.sample_valid ||
                   rsp_last !== exp_w.last ||
                   rsp_fill_level !== exp_w.fill_level ||
                   rsp_full_res !== exp_w.full_res ||
                   rsp_overwrote !== exp_w.overwrote) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: word mismatch exp sample=%h v=%b last=%b fill=%0d full=%b ovw=%b",
                              $realtime, exp_w.sample_out, exp_w.sample_valid, exp_w.last,
                              exp_w.fill_level, exp_w.full_res, exp_w.overwrote);
                     $display("%0t:               got sample=%h v=%b last=%b fill=%0d full=%b ovw=%b",
                              $realtime, rsp_sample_out, rsp_sample_valid, rsp_last,
                              rsp_fill_level, rsp_full_res, rsp_overwrote);
                  end
               end
            end
         end
         // Results of a newly taken command come out cycles later, so compare first.
         if (start && !busy)
            predict_words(action_type'(req_action), req_sample, req_request_count);
      end
      words_owed = owed_words.size();
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Top of the ring buffer bench: clock, reset, command stimulus, watchdog and verdict.
// Depends on orb_pkg, the overwriting_ring_buffer RTL and orb_checker.
module testbench;
   import orb_pkg::*;

   localparam int RANDOM_WORDS = 410;
   localparam int QUIET_TAIL   = 60;   // last commands go out with no idle gaps
   localparam int STALL_LIMIT  = 2000; // cycles with no handshake before giving up

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ACTION_W-1:0] req_action = '0;
   logic [DATA_W-1:0]   req_sample = '0;
   logic [REQ_W-1:0]    req_request_count = '0;
   logic                rsp_strobe;
   logic [DATA_W-1:0]   rsp_sample_out;
   logic                rsp_sample_valid;
   logic                rsp_last;
   logic [FILL_W-1:0]   rsp_fill_level;
   logic                rsp_full_res;
   logic                rsp_overwrote;

   int mismatch_count;
   int words_owed;
   int quiet_cycles = 0;

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   overwriting_ring_buffer DUT (.*);

   orb_checker u_checker (.*);

   // Drop the run if neither a command nor a result word moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one command at the falling edge and hold it until the block takes it.
   // start stays high on return so back-to-back commands need no extra assignment.
   task automatic send_command(input action_type act, input logic [DATA_W-1:0] smp,
                               input int unsigned want);
      @(negedge clock);
      start             <= 1'b1;
      req_action        <= act;
      req_sample        <= smp;
      req_request_count <= REQ_W'(want);
      do @(posedge clock); while (busy);
   endtask

   // Hold start low for a number of cycles.
   task automatic hold_idle(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // One time in five, insert an idle burst with start held low.
   task automatic maybe_idle();
      if ($urandom_range(0, 4) == 0)
         hold_idle($urandom_range(1, 19));
   endtask

   // Stop sending and wait for every owed word to come out.
   task automatic settle();
      hold_idle(1);
      while (words_owed != 0)
         @(negedge clock);
   endtask

   initial begin
      int unsigned push_pct;
      int unsigned roll;
      int unsigned want;
      logic [DATA_W-1:0] smp;
      action_type act;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty buffer first, then edge values, saturation and clear.
      send_command(ACT_POP, '0, 3);
      send_command(ACT_PEEK, '0, 64);
      send_command(ACT_POP, '0, 0);
      send_command(ACT_CLEAR, '0, 0);
      send_command(ACT_PUSH, '0, 0);
      maybe_idle();
      send_command(ACT_PUSH, {DATA_W{1'b1}}, 64);
      send_command(ACT_PUSH, 64'h0123_4567_89ab_cdef, 0);
      send_command(ACT_PUSH, 64'h8000_0000_0000_0001, 0);
      send_command(ACT_PEEK, '0, 0);           // nothing wanted
      send_command(ACT_POP, {DATA_W{1'b1}}, 0);
      send_command(ACT_PEEK, '0, 2);
      maybe_idle();
      send_command(ACT_PEEK, '0, 64);          // more than stored: saturate
      send_command(ACT_POP, '0, 1);
      send_command(ACT_POP, '0, 64);           // drains the rest
      send_command(ACT_POP, '0, 1);            // empty again
      send_command(ACT_PUSH, 64'hfedc_ba98_7654_3210, 0);
      send_command(ACT_PUSH, 64'h5555_aaaa_5555_aaaa, 0);
      send_command(ACT_CLEAR, '0, 0);
      send_command(ACT_POP, '0, 5);            // after clear: nothing to give
      send_command(ACT_PEEK, '0, 1);
      send_command(ACT_PUSH, 64'h7fff_ffff_ffff_fffe, 0);
      send_command(ACT_PEEK, '0, 1);
      maybe_idle();

      // Random: blocks of 32 commands, each biased toward filling, balance or draining,
      // so the buffer runs full and overwrites often as well as emptying out.
      push_pct = 55;
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (k % 32 == 0) begin
            case ($urandom_range(0, 2))
               0:       push_pct = 35;
               1:       push_pct = 55;
               default: push_pct = 85;
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < push_pct)
            act = ACT_PUSH;
         else if (roll < push_pct + (97 - push_pct) / 2)
            act = ACT_POP;
         else if (roll < 97)
            act = ACT_PEEK;
         else
            act = ACT_CLEAR;

         roll = $urandom_range(0, 9);
         if (roll < 6)
            want = $urandom_range(1, 4);
         else if (roll < 9)
            want = $urandom_range(0, 64);
         else
            want = $urandom_range(33, 64);

         case ($urandom_range(0, 15))
            0:       smp = '0;
            1:       smp = {DATA_W{1'b1}};
            default: smp = {$urandom, $urandom};
         endcase

         send_command(act, smp, want);
         // Pause once midway until the block has emptied its output.
         if (k == RANDOM_WORDS / 2)
            settle();
         else if (k < RANDOM_WORDS - QUIET_TAIL)
            maybe_idle();
      end

      // Wait out the owed words, then a few cycles for anything stray.
      settle();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && words_owed == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
